@@ src/sbb_pkg.sv @@
// Shared types, constants and codes of the separable binomial blur.
`timescale 1ns / 1ps
`default_nettype none
package sbb_pkg;

    localparam int PIXEL_W        = 16;
    localparam int VALUE_W        = 20;
    localparam int COL_OUT_W      = 10;
    localparam int ROW_OUT_W      = 12;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_WIDTH_W    = 11;
    localparam int CFG_HEIGHT_W   = 13;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int MIN_DIM        = 2;
    localparam int LIM_W          = 17;

    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1
    } reg_idx_t;

    // result slots of one pixel: previous row then last row, left column then right
    localparam int SLOT_UP_PREV  = 0;
    localparam int SLOT_UP_LAST  = 1;
    localparam int SLOT_LOW_PREV = 2;
    localparam int SLOT_LOW_LAST = 3;
    localparam int SLOT_N        = 4;

    typedef enum logic [1:0] {
        DIV_9,
        DIV_12,
        DIV_16
    } div_t;

    localparam int HSUM_W      = PIXEL_W + 2;
    localparam int NUM_W       = PIXEL_W + 4;
    localparam int MUL_A_W     = NUM_W + 5;
    localparam int MUL_B_W     = 26;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int RECIP_SHIFT = 27;

    // value = (16*num + 4) / 9 or (4*num + 1) / 3, by reciprocal over 2^27
    localparam int SHIFT_9  = 4;
    localparam int ROUND_9  = 4;
    localparam int SHIFT_12 = 2;
    localparam int ROUND_12 = 1;
    localparam logic [MUL_B_W-1:0] RECIP_9 = 26'd14913081;
    localparam logic [MUL_B_W-1:0] RECIP_3 = 26'd44739243;

    typedef logic [PIXEL_W-1:0] pixel_t;

    typedef struct packed {
        pixel_t [2:0][2:0]      taps;
        logic [SLOT_N-1:0]      mask;
        logic [COL_OUT_W-1:0]   col;
        logic [ROW_OUT_W-1:0]   row;
        logic                   col_one;
        logic                   row_one;
    } job_t;

endpackage
`default_nettype wire

@@ src/sbb_if.sv @@
// Channel interfaces: pixel in, result out, register writes.
`timescale 1ns / 1ps
`default_nettype none
interface sbb_pixel_if import sbb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface sbb_result_if import sbb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [VALUE_W-1:0]   filtered_value;
    logic [COL_OUT_W-1:0] out_column;
    logic [ROW_OUT_W-1:0] out_row;
    logic                 run_last;
    logic                 frame_done;

    modport source (output valid, output filtered_value, output out_column,
                    output out_row, output run_last, output frame_done, input ready);
    modport sink   (input valid, input filtered_value, input out_column,
                    input out_row, input run_last, input frame_done, output ready);
endinterface

interface sbb_cfg_if import sbb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ src/sbb_line_buf.sv @@
// Two row memories of raw pixels with registered read.
`timescale 1ns / 1ps
`default_nettype none
module sbb_line_buf import sbb_pkg::*; #(
    parameter int  DEPTH = DEF_MAX_WIDTH,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  pixel_t        wr_older,
    input  pixel_t        wr_newer,
    output pixel_t        rd_older,
    output pixel_t        rd_newer
);

    pixel_t older_mem [DEPTH];
    pixel_t newer_mem [DEPTH];
    pixel_t rd_older_reg;
    pixel_t rd_newer_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            older_mem[wr_addr] <= wr_older;
            newer_mem[wr_addr] <= wr_newer;
        end
        if (rd_en)
        begin
            rd_older_reg <= older_mem[rd_addr];
            rd_newer_reg <= newer_mem[rd_addr];
        end
    end

    assign rd_older = rd_older_reg;
    assign rd_newer = rd_newer_reg;

endmodule
`default_nettype wire

@@ src/sbb_front.sv @@
// Raster counters, registers, row memory read-modify-write and 3x3 window.
`timescale 1ns / 1ps
`default_nettype none
module sbb_front import sbb_pkg::*; #(
    parameter int  MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int  MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int COL_W      = $clog2(MAX_WIDTH),
    localparam int ROW_W      = $clog2(MAX_HEIGHT)
) (
    input  logic             clk,
    input  logic             rst_n,
    sbb_pixel_if.sink        pixel,
    sbb_cfg_if.sink          cfg,
    output logic             mem_rd_en,
    output logic [COL_W-1:0] mem_rd_addr,
    output logic             mem_wr_en,
    output logic [COL_W-1:0] mem_wr_addr,
    output pixel_t           mem_wr_older,
    output pixel_t           mem_wr_newer,
    input  pixel_t           mem_rd_older,
    input  pixel_t           mem_rd_newer,
    output logic             job_valid,
    input  logic             job_ready,
    output job_t             job
);

    logic [CFG_WIDTH_W-1:0]  width_reg, width_next;
    logic [CFG_HEIGHT_W-1:0] height_reg, height_next;
    logic [COL_W-1:0]        col_reg, col_next;
    logic [ROW_W-1:0]        row_reg, row_next;

    logic                    s1_v_reg, s1_v_next;
    pixel_t                  s1_px_reg;
    logic [COL_W-1:0]        s1_addr_reg;
    logic [ROW_OUT_W-1:0]    s1_row_reg;
    logic [SLOT_N-1:0]       s1_mask_reg, s1_mask_next;
    logic                    s1_col_one_reg;
    logic                    s1_row_one_reg;
    pixel_t [2:0][2:0]       win_reg, win_next;

    logic [LIM_W-1:0]        w_eff;
    logic [LIM_W-1:0]        h_eff;
    logic [COL_W-1:0]        col_last;
    logic [ROW_W-1:0]        row_last;
    logic                    last_col;
    logic                    last_row;
    logic                    col_nz;
    logic                    row_nz;
    logic                    pix_fire;
    logic                    cfg_fire;
    logic                    s1_adv;

    always_comb
    begin
        w_eff = LIM_W'(width_reg);
        if (w_eff < LIM_W'(MIN_DIM))
            w_eff = LIM_W'(MIN_DIM);
        else if (w_eff > LIM_W'(MAX_WIDTH))
            w_eff = LIM_W'(MAX_WIDTH);
        h_eff = LIM_W'(height_reg);
        if (h_eff < LIM_W'(MIN_DIM))
            h_eff = LIM_W'(MIN_DIM);
        else if (h_eff > LIM_W'(MAX_HEIGHT))
            h_eff = LIM_W'(MAX_HEIGHT);
        col_last = COL_W'(w_eff - LIM_W'(1));
        row_last = ROW_W'(h_eff - LIM_W'(1));
    end

    assign last_col = (col_reg == col_last);
    assign last_row = (row_reg == row_last);
    assign col_nz   = (col_reg != '0);
    assign row_nz   = (row_reg != '0);

    assign cfg.ready   = 1'b1;
    assign cfg_fire    = cfg.valid && cfg.ready;
    assign s1_adv      = s1_v_reg && ((s1_mask_reg == '0) || job_ready);
    assign pixel.ready = !s1_v_reg || s1_adv;
    assign pix_fire    = pixel.valid && pixel.ready;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cfg_fire)
        begin
            case (cfg.index)
                REG_WIDTH:  width_next  = cfg.data[CFG_WIDTH_W-1:0];
                REG_HEIGHT: height_next = cfg.data[CFG_HEIGHT_W-1:0];
                default:    ;
            endcase
            if (cfg.index == REG_WIDTH || cfg.index == REG_HEIGHT)
            begin
                col_next = '0;
                row_next = '0;
            end
        end
        else if (pix_fire)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_comb
    begin
        s1_mask_next                = '0;
        s1_mask_next[SLOT_UP_PREV]  = row_nz && col_nz;
        s1_mask_next[SLOT_UP_LAST]  = row_nz && last_col;
        s1_mask_next[SLOT_LOW_PREV] = last_row && col_nz;
        s1_mask_next[SLOT_LOW_LAST] = last_row && last_col;
        s1_v_next = pix_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_v_reg);
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = mem_rd_older;
        win_next[1][2] = mem_rd_newer;
        win_next[2][2] = s1_px_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            s1_v_reg   <= 1'b0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            s1_v_reg   <= s1_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            s1_px_reg      <= pixel.pixel_in;
            s1_addr_reg    <= col_reg;
            s1_row_reg     <= ROW_OUT_W'(row_reg);
            s1_mask_reg    <= s1_mask_next;
            s1_col_one_reg <= (col_reg == COL_W'(1));
            s1_row_one_reg <= (row_reg == ROW_W'(1));
        end
        if (s1_adv)
            win_reg <= win_next;
    end

    assign mem_rd_en    = pix_fire;
    assign mem_rd_addr  = col_reg;
    assign mem_wr_en    = s1_adv;
    assign mem_wr_addr  = s1_addr_reg;
    assign mem_wr_older = mem_rd_newer;
    assign mem_wr_newer = s1_px_reg;

    assign job_valid    = s1_v_reg && (s1_mask_reg != '0);
    assign job.taps     = win_next;
    assign job.mask     = s1_mask_reg;
    assign job.col      = COL_OUT_W'(s1_addr_reg);
    assign job.row      = s1_row_reg;
    assign job.col_one  = s1_col_one_reg;
    assign job.row_one  = s1_row_one_reg;

endmodule
`default_nettype wire

@@ src/sbb_arith.sv @@
// Result sequencer and weighted sum, rounding divide and output pipeline.
`timescale 1ns / 1ps
`default_nettype none
module sbb_arith import sbb_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    output logic        job_ready,
    input  job_t        job,
    sbb_result_if.source result
);

    // result slot sequencer
    logic                    s2_v_reg, s2_v_next;
    logic [SLOT_N-1:0]       s2_mask_reg, s2_mask_next;
    job_t                    s2_job_reg;

    // horizontal sums
    logic                    s3_v_reg, s3_v_next;
    logic [2:0][HSUM_W-1:0]  s3_h_reg, s3_h_next;
    logic                    s3_top_reg, s3_bottom_reg;
    div_t                    s3_div_reg, s3_div_next;
    logic [COL_OUT_W-1:0]    s3_col_reg, s3_col_next;
    logic [ROW_OUT_W-1:0]    s3_row_reg, s3_row_next;
    logic                    s3_last_reg, s3_done_reg;

    // vertical sum
    logic                    s4_v_reg, s4_v_next;
    logic [NUM_W-1:0]        s4_num_reg, s4_num_next;
    div_t                    s4_div_reg;
    logic [COL_OUT_W-1:0]    s4_col_reg;
    logic [ROW_OUT_W-1:0]    s4_row_reg;
    logic                    s4_last_reg, s4_done_reg;

    // reciprocal product
    logic                    s5_v_reg, s5_v_next;
    logic [PROD_W-1:0]       s5_prod_reg, s5_prod_next;
    logic [NUM_W-1:0]        s5_num_reg;
    div_t                    s5_div_reg;
    logic [COL_OUT_W-1:0]    s5_col_reg;
    logic [ROW_OUT_W-1:0]    s5_row_reg;
    logic                    s5_last_reg, s5_done_reg;

    // output
    logic                    out_v_reg, out_v_next;
    logic [VALUE_W-1:0]      out_value_reg, out_value_next;
    logic [COL_OUT_W-1:0]    out_col_reg;
    logic [ROW_OUT_W-1:0]    out_row_reg;
    logic                    out_last_reg, out_done_reg;

    logic                    out_rdy, s5_rdy, s4_rdy, s3_rdy;
    logic                    s2_fire;
    logic [1:0]              slot;
    logic [SLOT_N-1:0]       rest;
    logic                    rb, cb;
    logic                    left, right, top, bottom;
    pixel_t [2:0][2:0]       rows_sel;
    pixel_t [2:0][2:0]       win_sel;
    logic [MUL_A_W-1:0]      mul_a;
    logic [MUL_B_W-1:0]      mul_b;

    assign out_rdy = !out_v_reg || result.ready;
    assign s5_rdy  = !s5_v_reg || out_rdy;
    assign s4_rdy  = !s4_v_reg || s5_rdy;
    assign s3_rdy  = !s3_v_reg || s4_rdy;

    always_comb
    begin
        slot = 2'd0;
        for (int i = SLOT_N - 1; i >= 0; i--)
        begin
            if (s2_mask_reg[i])
                slot = 2'(i);
        end
        rest       = s2_mask_reg;
        rest[slot] = 1'b0;
    end

    assign rb        = slot[1];
    assign cb        = slot[0];
    assign s2_fire   = s2_v_reg && s3_rdy;
    assign job_ready = !s2_v_reg || (s3_rdy && (rest == '0));

    always_comb
    begin
        s2_v_next    = s2_v_reg;
        s2_mask_next = s2_mask_reg;
        if (job_valid && job_ready)
        begin
            s2_v_next    = 1'b1;
            s2_mask_next = job.mask;
        end
        else if (s2_fire)
        begin
            s2_v_next    = (rest != '0);
            s2_mask_next = rest;
        end
    end

    // window rows rb..rb+2 and columns cb..cb+2, zero past the edge
    always_comb
    begin
        rows_sel[0] = rb ? s2_job_reg.taps[1] : s2_job_reg.taps[0];
        rows_sel[1] = rb ? s2_job_reg.taps[2] : s2_job_reg.taps[1];
        rows_sel[2] = rb ? '0 : s2_job_reg.taps[2];
        for (int i = 0; i < 3; i++)
        begin
            win_sel[i][0] = cb ? rows_sel[i][1] : rows_sel[i][0];
            win_sel[i][1] = cb ? rows_sel[i][2] : rows_sel[i][1];
            win_sel[i][2] = cb ? '0 : rows_sel[i][2];
        end
    end

    assign left   = !cb && s2_job_reg.col_one;
    assign right  = cb;
    assign top    = !rb && s2_job_reg.row_one;
    assign bottom = rb;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (left)
                s3_h_next[i] = (HSUM_W'(win_sel[i][1]) << 1) + HSUM_W'(win_sel[i][2]);
            else if (right)
                s3_h_next[i] = HSUM_W'(win_sel[i][0]) + (HSUM_W'(win_sel[i][1]) << 1);
            else
                s3_h_next[i] = HSUM_W'(win_sel[i][0]) + (HSUM_W'(win_sel[i][1]) << 1)
                             + HSUM_W'(win_sel[i][2]);
        end
        if ((left || right) && (top || bottom))
            s3_div_next = DIV_9;
        else if (left || right || top || bottom)
            s3_div_next = DIV_12;
        else
            s3_div_next = DIV_16;
        s3_col_next = cb ? s2_job_reg.col : s2_job_reg.col - COL_OUT_W'(1);
        s3_row_next = rb ? s2_job_reg.row : s2_job_reg.row - ROW_OUT_W'(1);
        s3_v_next   = s2_fire ? 1'b1 : (s4_rdy ? 1'b0 : s3_v_reg);
    end

    always_comb
    begin
        if (s3_top_reg)
            s4_num_next = (NUM_W'(s3_h_reg[1]) << 1) + NUM_W'(s3_h_reg[2]);
        else if (s3_bottom_reg)
            s4_num_next = NUM_W'(s3_h_reg[0]) + (NUM_W'(s3_h_reg[1]) << 1);
        else
            s4_num_next = NUM_W'(s3_h_reg[0]) + (NUM_W'(s3_h_reg[1]) << 1)
                        + NUM_W'(s3_h_reg[2]);
        s4_v_next = (s3_v_reg && s4_rdy) ? 1'b1 : (s5_rdy ? 1'b0 : s4_v_reg);
    end

    always_comb
    begin
        case (s4_div_reg)
            DIV_9:
            begin
                mul_a = (MUL_A_W'(s4_num_reg) << SHIFT_9) + MUL_A_W'(ROUND_9);
                mul_b = RECIP_9;
            end
            DIV_12:
            begin
                mul_a = (MUL_A_W'(s4_num_reg) << SHIFT_12) + MUL_A_W'(ROUND_12);
                mul_b = RECIP_3;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        s5_prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
        s5_v_next    = (s4_v_reg && s5_rdy) ? 1'b1 : (out_rdy ? 1'b0 : s5_v_reg);
    end

    always_comb
    begin
        if (s5_div_reg == DIV_16)
            out_value_next = VALUE_W'(s5_num_reg);
        else
            out_value_next = s5_prod_reg[RECIP_SHIFT +: VALUE_W];
        out_v_next = (s5_v_reg && out_rdy) ? 1'b1 : (result.ready ? 1'b0 : out_v_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg    <= 1'b0;
            s2_mask_reg <= '0;
            s3_v_reg    <= 1'b0;
            s4_v_reg    <= 1'b0;
            s5_v_reg    <= 1'b0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            s2_v_reg    <= s2_v_next;
            s2_mask_reg <= s2_mask_next;
            s3_v_reg    <= s3_v_next;
            s4_v_reg    <= s4_v_next;
            s5_v_reg    <= s5_v_next;
            out_v_reg   <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && job_ready)
            s2_job_reg <= job;
        if (s2_fire)
        begin
            s3_h_reg      <= s3_h_next;
            s3_top_reg    <= top;
            s3_bottom_reg <= bottom;
            s3_div_reg    <= s3_div_next;
            s3_col_reg    <= s3_col_next;
            s3_row_reg    <= s3_row_next;
            s3_last_reg   <= (rest == '0);
            s3_done_reg   <= (slot == 2'(SLOT_LOW_LAST));
        end
        if (s3_v_reg && s4_rdy)
        begin
            s4_num_reg  <= s4_num_next;
            s4_div_reg  <= s3_div_reg;
            s4_col_reg  <= s3_col_reg;
            s4_row_reg  <= s3_row_reg;
            s4_last_reg <= s3_last_reg;
            s4_done_reg <= s3_done_reg;
        end
        if (s4_v_reg && s5_rdy)
        begin
            s5_prod_reg <= s5_prod_next;
            s5_num_reg  <= s4_num_reg;
            s5_div_reg  <= s4_div_reg;
            s5_col_reg  <= s4_col_reg;
            s5_row_reg  <= s4_row_reg;
            s5_last_reg <= s4_last_reg;
            s5_done_reg <= s4_done_reg;
        end
        if (s5_v_reg && out_rdy)
        begin
            out_value_reg <= out_value_next;
            out_col_reg   <= s5_col_reg;
            out_row_reg   <= s5_row_reg;
            out_last_reg  <= s5_last_reg;
            out_done_reg  <= s5_done_reg;
        end
    end

    assign result.valid          = out_v_reg;
    assign result.filtered_value = out_value_reg;
    assign result.out_column     = out_col_reg;
    assign result.out_row        = out_row_reg;
    assign result.run_last       = out_last_reg;
    assign result.frame_done     = out_done_reg;

endmodule
`default_nettype wire

@@ src/separable_binomial_blur_3x3.sv @@
// Top level of the separable 3x3 binomial blur over a raster pixel stream.
//
//   channel   dir   beat payload                                        handshake
//   pixel     in    pixel_in                                            valid/ready
//   result    out   filtered_value, out_column, out_row, run_last,      valid/ready
//                   frame_done
//   cfg       in    index (0 width, 1 height), data                     valid/ready
//
// One pixel beat per cycle when not stalled. The result port moves one beat per
// cycle, so a pixel with k results holds the pixel port until all k are issued:
// two at the last column of every row after the first and at every column but
// the first of the last row, four at the final pixel.
// Reset restores 640 x 480, clears counters and pipeline valids; row memories
// need no clearing.
// A stall on result backs up through the pipeline and holds pixel ready low.
`timescale 1ns / 1ps
`default_nettype none
module separable_binomial_blur_3x3 import sbb_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic         clk,
    input  logic         rst_n,
    sbb_pixel_if.sink    pixel,
    sbb_result_if.source result,
    sbb_cfg_if.sink      cfg
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic             mem_rd_en;
    logic [COL_W-1:0] mem_rd_addr;
    logic             mem_wr_en;
    logic [COL_W-1:0] mem_wr_addr;
    pixel_t           mem_wr_older;
    pixel_t           mem_wr_newer;
    pixel_t           mem_rd_older;
    pixel_t           mem_rd_newer;
    logic             job_valid;
    logic             job_ready;
    job_t             job;

    sbb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel        (pixel),
        .cfg          (cfg),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_addr  (mem_rd_addr),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_older (mem_wr_older),
        .mem_wr_newer (mem_wr_newer),
        .mem_rd_older (mem_rd_older),
        .mem_rd_newer (mem_rd_newer),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job          (job)
    );

    sbb_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk      (clk),
        .rd_en    (mem_rd_en),
        .rd_addr  (mem_rd_addr),
        .wr_en    (mem_wr_en),
        .wr_addr  (mem_wr_addr),
        .wr_older (mem_wr_older),
        .wr_newer (mem_wr_newer),
        .rd_older (mem_rd_older),
        .rd_newer (mem_rd_newer)
    );

    sbb_arith u_arith (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .result    (result)
    );

endmodule
`default_nettype wire

@@ tb/sv/tb_separable_binomial_blur_3x3.sv @@
// Self-checking testbench for the separable 3x3 binomial blur with a built-in blur predictor.
`timescale 1ns / 1ps
module tb_separable_binomial_blur_3x3;
    import sbb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam int RANDOM_ITEMS = 200;
    localparam int HOLD_OFF     = 16;
    localparam int QUIET_LIMIT  = 2000;
    localparam int IDLE_PCT     = 32;

    typedef struct packed {
        logic [VALUE_W-1:0]   value;
        logic [COL_OUT_W-1:0] col;
        logic [ROW_OUT_W-1:0] row;
        logic                 run_last;
        logic                 frame_done;
    } blur_beat_t;

    logic clk;
    logic rst_n;

    sbb_pixel_if  pix_ch ();
    sbb_result_if res_ch ();
    sbb_cfg_if    cfg_ch ();

    separable_binomial_blur_3x3 uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pix_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    pixel_t                  pending_pixels [$];
    blur_beat_t              expected_blurs [$];
    int unsigned             mismatch_count;
    int unsigned             pix_idle_pct;
    int unsigned             res_idle_pct;
    int unsigned             quiet_cycles;

    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    pixel_t                  older_row [DEF_MAX_WIDTH];
    pixel_t                  newer_row [DEF_MAX_WIDTH];
    pixel_t                  win [3][3];
    int unsigned             next_col;
    int unsigned             next_row;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned clamp_dim(int unsigned raw, int unsigned hi);
        if (raw < MIN_DIM)
            return MIN_DIM;
        if (raw > hi)
            return hi;
        return raw;
    endfunction

    function automatic longint unsigned win_tap(int unsigned r, int unsigned k);
        if (r > 2 || k > 2)
            return 0;
        return win[r][k];
    endfunction

    function automatic longint unsigned row_sum(int unsigned r, int unsigned cb,
                                                bit lft, bit rgt);
        longint unsigned centre;
        centre = win_tap(r, cb + 1);
        if (lft)
            return 2 * centre + win_tap(r, cb + 2);
        if (rgt)
            return win_tap(r, cb) + 2 * centre;
        return win_tap(r, cb) + 2 * centre + win_tap(r, cb + 2);
    endfunction

    function automatic blur_beat_t blur_at(int unsigned row, int unsigned col,
                                           int unsigned rb, int unsigned cb,
                                           int unsigned w, int unsigned h);
        blur_beat_t      b;
        bit              lft;
        bit              rgt;
        bit              top;
        bit              bot;
        longint unsigned num;
        longint unsigned dv;
        lft = (col == 0);
        rgt = (col == w - 1);
        top = (row == 0);
        bot = (row == h - 1);
        dv  = ((lft || rgt) ? 3 : 4) * ((top || bot) ? 3 : 4);
        if (top)
            num = 2 * row_sum(rb + 1, cb, lft, rgt) + row_sum(rb + 2, cb, lft, rgt);
        else if (bot)
            num = row_sum(rb, cb, lft, rgt) + 2 * row_sum(rb + 1, cb, lft, rgt);
        else
            num = row_sum(rb, cb, lft, rgt) + 2 * row_sum(rb + 1, cb, lft, rgt)
                + row_sum(rb + 2, cb, lft, rgt);
        b.value      = VALUE_W'((32 * num + dv) / (2 * dv));
        b.col        = COL_OUT_W'(col);
        b.row        = ROW_OUT_W'(row);
        b.run_last   = 1'b0;
        b.frame_done = bot && rgt;
        return b;
    endfunction

    function automatic void blur_pixel(pixel_t px);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        int unsigned n;
        int          r;
        pixel_t      up;
        pixel_t      mid;
        bit          last_col;
        bit          last_row;
        blur_beat_t  fresh [SLOT_N];
        w = clamp_dim(width_reg, DEF_MAX_WIDTH);
        h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
        x = (next_col >= w) ? w - 1 : next_col;
        y = (next_row >= h) ? h - 1 : next_row;
        last_col = (x == w - 1);
        last_row = (y == h - 1);
        n = 0;
        up  = older_row[x];
        mid = newer_row[x];
        older_row[x] = mid;
        newer_row[x] = px;
        for (r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = up;
        win[1][2] = mid;
        win[2][2] = px;
        if (y >= 1)
        begin
            if (x >= 1)
            begin
                fresh[n] = blur_at(y - 1, x - 1, 0, 0, w, h);
                n++;
            end
            if (last_col)
            begin
                fresh[n] = blur_at(y - 1, x, 0, 1, w, h);
                n++;
            end
        end
        if (last_row)
        begin
            if (x >= 1)
            begin
                fresh[n] = blur_at(y, x - 1, 1, 0, w, h);
                n++;
            end
            if (last_col)
            begin
                fresh[n] = blur_at(y, x, 1, 1, w, h);
                n++;
            end
        end
        if (n > 0)
            fresh[n - 1].run_last = 1'b1;
        for (r = 0; r < int'(n); r++)
            expected_blurs.push_back(fresh[r]);
        if (last_col)
        begin
            next_col = 0;
            next_row = last_row ? 0 : y + 1;
        end
        else
        begin
            next_col = x + 1;
            next_row = y;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : pixel_driver
        if (!rst_n)
        begin
            pix_ch.valid    <= 1'b0;
            pix_ch.pixel_in <= '0;
        end
        else
        begin
            if (pix_ch.valid && pix_ch.ready)
                blur_pixel(pix_ch.pixel_in);
            if (!(pix_ch.valid && !pix_ch.ready))
            begin
                if (pending_pixels.size() != 0 && $urandom_range(99) >= pix_idle_pct)
                begin
                    pix_ch.valid    <= 1'b1;
                    pix_ch.pixel_in <= pending_pixels.pop_front();
                end
                else
                    pix_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        blur_beat_t seen;
        blur_beat_t want;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                seen = '{value: res_ch.filtered_value, col: res_ch.out_column,
                         row: res_ch.out_row, run_last: res_ch.run_last,
                         frame_done: res_ch.frame_done};
                if (expected_blurs.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected beat: expected none, actual value %0d col %0d",
                             $time, seen.value, seen.col);
                    $display("%0t:   row %0d last %0b done %0b",
                             $time, seen.row, seen.run_last, seen.frame_done);
                end
                else
                begin
                    want = expected_blurs.pop_front();
                    if (seen !== want)
                    begin
                        mismatch_count++;
                        $display("%0t: expected value %0d col %0d row %0d last %0b done %0b",
                                 $time, want.value, want.col, want.row, want.run_last,
                                 want.frame_done);
                        $display("%0t:   actual value %0d col %0d row %0d last %0b done %0b",
                                 $time, seen.value, seen.col, seen.row, seen.run_last,
                                 seen.frame_done);
                    end
                end
            end
            res_ch.ready <= ($urandom_range(99) >= res_idle_pct);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : watchdog
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)
                 || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
            $display("FAIL separable_binomial_blur_3x3");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_WIDTH)
        begin
            width_reg = val[CFG_WIDTH_W-1:0];
            next_col  = 0;
            next_row  = 0;
        end
        else if (idx == REG_HEIGHT)
        begin
            height_reg = val[CFG_HEIGHT_W-1:0];
            next_col   = 0;
            next_row   = 0;
        end
    endtask

    task automatic settle();
        while (pending_pixels.size() != 0 || pix_ch.valid)
            @(posedge clk);
        while (expected_blurs.size() != 0)
            @(posedge clk);
        repeat (HOLD_OFF) @(posedge clk);
    endtask

    task automatic push_random(int unsigned n);
        repeat (n)
        begin
            case ($urandom_range(7))
                0:       pending_pixels.push_back('0);
                1:       pending_pixels.push_back('1);
                default: pending_pixels.push_back(pixel_t'($urandom_range(16'hFFFF)));
            endcase
        end
    endtask

    initial
    begin : stimulus
        int unsigned           n;
        int unsigned           sent;
        int unsigned           phase;
        logic [CFG_DATA_W-1:0] data;

        rst_n           = 1'b0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= REG_WIDTH;
        cfg_ch.data     <= '0;
        width_reg       = WIDTH_RESET;
        height_reg      = HEIGHT_RESET;
        next_col        = 0;
        next_row        = 0;
        mismatch_count  = 0;
        pix_idle_pct    = IDLE_PCT;
        res_idle_pct    = IDLE_PCT;
        foreach (older_row[i])
        begin
            older_row[i] = '0;
            newer_row[i] = '0;
        end
        foreach (win[i, j])
            win[i][j] = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // smallest frame: every pixel is a corner, final pixel yields four beats
        write_reg(REG_WIDTH, 13'd2);
        write_reg(REG_HEIGHT, 13'd2);
        pending_pixels.push_back(16'hFFFF);
        pending_pixels.push_back(16'h0000);
        pending_pixels.push_back(16'h0000);
        pending_pixels.push_back(16'hFFFF);
        settle();

        // full-scale interior, edges and corners
        write_reg(REG_WIDTH, 13'd3);
        write_reg(REG_HEIGHT, 13'd3);
        repeat (9) pending_pixels.push_back(16'hFFFF);
        settle();

        // sizes below the minimum act as 2
        write_reg(REG_WIDTH, 13'd0);
        write_reg(REG_HEIGHT, 13'd1);
        pending_pixels.push_back(16'hAAAA);
        pending_pixels.push_back(16'h5555);
        pending_pixels.push_back(16'h5555);
        pending_pixels.push_back(16'hAAAA);
        settle();

        // upper data bits of a width write are dropped; spare index leaves the frame going
        write_reg(REG_WIDTH, 13'h1804);
        write_reg(REG_HEIGHT, 13'd2);
        push_random(5);
        settle();
        write_reg(REG_SPARE_LO, 13'h1FFF);
        push_random(3);
        settle();
        write_reg(REG_SPARE_HI, 13'h0000);

        // largest sizes, partial frames cut short by the next write
        write_reg(REG_WIDTH, 13'd1024);
        write_reg(REG_HEIGHT, 13'd1);
        push_random(24);
        settle();
        write_reg(REG_WIDTH, 13'd2047);
        write_reg(REG_HEIGHT, 13'd3);
        push_random(24);
        settle();
        write_reg(REG_WIDTH, 13'd2);
        write_reg(REG_HEIGHT, 13'd4096);
        push_random(24);
        settle();
        write_reg(REG_HEIGHT, 13'd8191);
        write_reg(REG_WIDTH, 13'd1);
        push_random(20);
        settle();

        write_reg(REG_WIDTH, 13'd5);
        write_reg(REG_HEIGHT, 13'd4);
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            settle();
            pix_idle_pct = (phase >= 2 && phase <= 3) ? 0 : IDLE_PCT;
            res_idle_pct = pix_idle_pct;
            case ($urandom_range(4))
                0:
                begin
                    data = CFG_DATA_W'($urandom_range(9));
                    data[CFG_DATA_W-1:CFG_WIDTH_W] = 2'($urandom_range(3));
                    write_reg(REG_WIDTH, data);
                end
                1:
                    write_reg(REG_HEIGHT, CFG_DATA_W'($urandom_range(6)));
                2:
                begin
                    write_reg(REG_HEIGHT, CFG_DATA_W'($urandom_range(6)));
                    write_reg(REG_WIDTH, CFG_DATA_W'($urandom_range(9)));
                end
                3:
                    write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                              CFG_DATA_W'($urandom_range(13'h1FFF)));
                default:
                    ;
            endcase
            n = $urandom_range(4, 3 * clamp_dim(width_reg, DEF_MAX_WIDTH)
                                    * clamp_dim(height_reg, DEF_MAX_HEIGHT));
            push_random(n);
            sent  += n;
            phase += 1;
        end

        settle();
        if (mismatch_count == 0)
            $display("PASS separable_binomial_blur_3x3");
        else
            $display("FAIL separable_binomial_blur_3x3");
        $finish;
    end

endmodule
